/* rtl/core/nabps_pkg.sv */
package nabps_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 10;
  localparam int DIST_W     = 41;
  localparam int DIST_OUT_W = 40;
  localparam int SUM_W      = 24;

  // result queue sizing
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

  // per-word control travelling down the pixel pipeline
  typedef struct packed {
    logic             valid;
    logic             hi_en;
    logic             pix_end;
    logic             frame_end;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pix_ctl_t;

  // one result record, last field in the lowest bits
  typedef struct packed {
    logic [SUM_W-1:0]      bright_sum;
    logic [POS_W-1:0]      bright_col;
    logic [POS_W-1:0]      bright_row;
    logic [DIST_OUT_W-1:0] nearest_dist_sq;
    logic [POS_W-1:0]      nearest_col;
    logic [POS_W-1:0]      nearest_row;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

/* rtl/core/nabps_ram.sv */
module nabps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/nabps_accum.sv */
module nabps_accum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nabps_pkg::pix_ctl_t             s1_ctl,
  input  logic [nabps_pkg::SAMPLE_W-1:0]  s1_lo,
  input  logic [nabps_pkg::SAMPLE_W-1:0]  s1_hi,
  input  logic [nabps_pkg::SAMPLE_W-1:0]  ref_lo,
  input  logic [nabps_pkg::SAMPLE_W-1:0]  ref_hi,
  output nabps_pkg::pix_ctl_t             pix_ctl,
  output logic [nabps_pkg::DIST_W-1:0]    pix_dist,
  output logic [nabps_pkg::SUM_W-1:0]     pix_sum
);

  import nabps_pkg::*;

  logic [SAMPLE_W-1:0]   d_lo, d_hi, hi_smp, hi_ref;
  logic [2*SAMPLE_W-1:0] sq_lo_nxt, sq_hi_nxt;
  logic [SAMPLE_W:0]     bsum_nxt;

  pix_ctl_t              s2_ctl_r;
  logic [2*SAMPLE_W-1:0] sq_lo_r, sq_hi_r;
  logic [SAMPLE_W:0]     bsum_r;

  logic [DIST_W-1:0]     dacc_r, dist_sat;
  logic [SUM_W-1:0]      sacc_r, sum_sat;
  logic [DIST_W:0]       dist_full;
  logic [SUM_W:0]        sum_full;

  pix_ctl_t              pix_ctl_r, pix_ctl_nxt;
  logic [DIST_W-1:0]     pix_dist_r;
  logic [SUM_W-1:0]      pix_sum_r;

  // absolute differences, upper band masked past the band count
  always_comb begin
    hi_smp    = s1_ctl.hi_en ? s1_hi  : '0;
    hi_ref    = s1_ctl.hi_en ? ref_hi : '0;
    d_lo      = (s1_lo > ref_lo) ? (s1_lo - ref_lo) : (ref_lo - s1_lo);
    d_hi      = (hi_smp > hi_ref) ? (hi_smp - hi_ref) : (hi_ref - hi_smp);
    sq_lo_nxt = (2*SAMPLE_W)'(d_lo) * (2*SAMPLE_W)'(d_lo);
    sq_hi_nxt = (2*SAMPLE_W)'(d_hi) * (2*SAMPLE_W)'(d_hi);
    bsum_nxt  = (SAMPLE_W+1)'(s1_lo) + (SAMPLE_W+1)'(hi_smp);
  end

  // squares stage
  always_ff @(posedge clk) begin
    sq_lo_r <= sq_lo_nxt;
    sq_hi_r <= sq_hi_nxt;
    bsum_r  <= bsum_nxt;
  end

  // saturating accumulation of the current pixel
  always_comb begin
    dist_full = (DIST_W+1)'(dacc_r) + (DIST_W+1)'(sq_lo_r) + (DIST_W+1)'(sq_hi_r);
    dist_sat  = dist_full[DIST_W] ? '1 : dist_full[DIST_W-1:0];
    sum_full  = (SUM_W+1)'(sacc_r) + (SUM_W+1)'(bsum_r);
    sum_sat   = sum_full[SUM_W] ? '1 : sum_full[SUM_W-1:0];
  end

  // control passed on only at the end of a pixel
  always_comb begin
    pix_ctl_nxt       = s2_ctl_r;
    pix_ctl_nxt.valid = s2_ctl_r.valid & s2_ctl_r.pix_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r  <= '0;
      pix_ctl_r <= '0;
      dacc_r    <= '0;
      sacc_r    <= '0;
    end else begin
      s2_ctl_r  <= s1_ctl;
      pix_ctl_r <= pix_ctl_nxt;
      if (s2_ctl_r.valid) begin
        if (s2_ctl_r.pix_end) begin
          dacc_r <= '0;
          sacc_r <= '0;
        end else begin
          dacc_r <= dist_sat;
          sacc_r <= sum_sat;
        end
      end
    end
  end

  // pixel totals
  always_ff @(posedge clk) begin
    pix_dist_r <= dist_sat;
    pix_sum_r  <= sum_sat;
  end

  assign pix_ctl  = pix_ctl_r;
  assign pix_dist = pix_dist_r;
  assign pix_sum  = pix_sum_r;

endmodule

/* rtl/core/nabps_track.sv */
module nabps_track (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nabps_pkg::pix_ctl_t          pix_ctl,
  input  logic [nabps_pkg::DIST_W-1:0] pix_dist,
  input  logic [nabps_pkg::SUM_W-1:0]  pix_sum,
  output logic                         res_push,
  output nabps_pkg::result_t           res
);

  import nabps_pkg::*;

  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic [POS_W-1:0]  best_dist_row_r, best_dist_row_nxt;
  logic [POS_W-1:0]  best_dist_col_r, best_dist_col_nxt;
  logic [SUM_W-1:0]  best_sum_r, best_sum_nxt;
  logic [POS_W-1:0]  best_sum_row_r, best_sum_row_nxt;
  logic [POS_W-1:0]  best_sum_col_r, best_sum_col_nxt;

  // strict compares keep the earliest pixel on ties
  always_comb begin
    best_dist_nxt     = best_dist_r;
    best_dist_row_nxt = best_dist_row_r;
    best_dist_col_nxt = best_dist_col_r;
    best_sum_nxt      = best_sum_r;
    best_sum_row_nxt  = best_sum_row_r;
    best_sum_col_nxt  = best_sum_col_r;
    if (pix_ctl.valid && (pix_dist < best_dist_r)) begin
      best_dist_nxt     = pix_dist;
      best_dist_row_nxt = pix_ctl.row;
      best_dist_col_nxt = pix_ctl.col;
    end
    if (pix_ctl.valid && (pix_sum > best_sum_r)) begin
      best_sum_nxt     = pix_sum;
      best_sum_row_nxt = pix_ctl.row;
      best_sum_col_nxt = pix_ctl.col;
    end
  end

  // result record built from the updated trackers
  always_comb begin
    res_push            = pix_ctl.valid & pix_ctl.frame_end;
    res.nearest_row     = best_dist_row_nxt;
    res.nearest_col     = best_dist_col_nxt;
    res.nearest_dist_sq = best_dist_nxt[DIST_W-1] ? '1 : best_dist_nxt[DIST_OUT_W-1:0];
    res.bright_row      = best_sum_row_nxt;
    res.bright_col      = best_sum_col_nxt;
    res.bright_sum      = best_sum_nxt;
  end

  // trackers clear after each frame
  always_ff @(posedge clk) begin
    if (!rst_n || res_push) begin
      best_dist_r     <= '1;
      best_dist_row_r <= '0;
      best_dist_col_r <= '0;
      best_sum_r      <= '0;
      best_sum_row_r  <= '0;
      best_sum_col_r  <= '0;
    end else begin
      best_dist_r     <= best_dist_nxt;
      best_dist_row_r <= best_dist_row_nxt;
      best_dist_col_r <= best_dist_col_nxt;
      best_sum_r      <= best_sum_nxt;
      best_sum_row_r  <= best_sum_row_nxt;
      best_sum_col_r  <= best_sum_col_nxt;
    end
  end

endmodule

/* rtl/core/nabps_fifo.sv */
module nabps_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nabps_pkg::result_t din,
  input  logic               pop,
  output logic               valid,
  output logic               full,
  output nabps_pkg::result_t dout
);

  import nabps_pkg::*;

  result_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PEND_W-1:0] count_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + PEND_W'(push) - PEND_W'(pop);
    end
  end

  assign valid = (count_r != '0);
  assign full  = (count_r == PEND_W'(FIFO_DEPTH));
  assign dout  = mem[rd_ptr_r];

endmodule

/* rtl/core/nearest_and_brightest_pixel_search.sv */
// channel | dir | handshake           | payload
// --------+-----+---------------------+---------------------------------------------
// in_     | in  | in_tvalid/in_tready | tuser: command; tdata: sample_lo, sample_hi
// out_    | out | out_tvalid/tready   | tdata: nearest row/col/dist_sq, bright row/col/sum
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index 0 bands, 1 rows, 2 cols; cfg_data
//
// one word is taken every cycle unless in_tready is low; the reference store is two
// half-depth banks so a word reads or writes both of its bands through one port each
// the last word of a frame passes the first stage, the squares stage and the pixel register before its result is queued
// in_tready drops only while eight results are outstanding (queued or in flight)
// rst_n is synchronous; the reference store is not cleared and must be loaded
// before pixels arrive; counts reset to 256 bands by 1024 rows by 1024 columns
module nearest_and_brightest_pixel_search #(
  parameter int MAX_BANDS = 256,
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_COLS  = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // sample_lo[15:0], sample_hi[31:16]
  input  logic                        in_tuser,   // command[0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // nearest_row[9:0], nearest_col[19:10], nearest_dist_sq[59:20],
  // bright_row[69:60], bright_col[79:70], bright_sum[103:80]
  output logic [nabps_pkg::RES_W-1:0] out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [10:0]                 cfg_data
);

  import nabps_pkg::*;

  localparam int BPW = $clog2(MAX_BANDS);
  localparam int BCW = $clog2(MAX_BANDS + 3);
  localparam int HD  = (MAX_BANDS + 1) / 2;
  localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
  localparam int RPW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 2);
  localparam int CPW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CCW = $clog2(MAX_COLS + 2);

  typedef enum logic [1:0] {
    REG_BAND_COUNT = 2'd0,
    REG_ROW_COUNT  = 2'd1,
    REG_COL_COUNT  = 2'd2
  } cfg_reg_t;

  logic [8:0]  band_count_r;
  logic [10:0] row_count_r, col_count_r;

  logic [BCW-1:0] bands;
  logic [RCW-1:0] rows;
  logic [CCW-1:0] cols;

  logic [BPW-1:0] ref_fill_r, ref_fill_nxt;
  logic [BPW-1:0] band_pos_r, band_pos_nxt;
  logic [RPW-1:0] row_pos_r, row_pos_nxt;
  logic [CPW-1:0] col_pos_r, col_pos_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  logic           in_acc, pix_acc, ref_acc;
  logic [BCW-1:0] fill0, fill_adv, bp_ext;
  logic           ref_hi_we;
  logic [HAW-1:0] ref_waddr, ref_raddr;
  logic           hi_en, pix_end, col_end, row_end, frame_end;

  pix_ctl_t            s1_ctl_r, s1_ctl_nxt;
  logic [SAMPLE_W-1:0] s1_lo_r, s1_hi_r, ref_lo, ref_hi;

  pix_ctl_t          pix_ctl;
  logic [DIST_W-1:0] pix_dist;
  logic [SUM_W-1:0]  pix_sum;
  logic              res_push, fifo_full, out_pop;
  result_t           res, head;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_count_r <= 9'd256;
      row_count_r  <= 11'd1024;
      col_count_r  <= 11'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BAND_COUNT: band_count_r <= cfg_data[8:0];
        REG_ROW_COUNT:  row_count_r  <= cfg_data;
        REG_COL_COUNT:  col_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective counts: zero acts as one, limited to the maximum
  always_comb begin
    if (band_count_r == '0) bands = BCW'(1);
    else if (32'(band_count_r) > MAX_BANDS) bands = BCW'(MAX_BANDS);
    else bands = BCW'(band_count_r);
    if (row_count_r == '0) rows = RCW'(1);
    else if (32'(row_count_r) > MAX_ROWS) rows = RCW'(MAX_ROWS);
    else rows = RCW'(row_count_r);
    if (col_count_r == '0) cols = CCW'(1);
    else if (32'(col_count_r) > MAX_COLS) cols = CCW'(MAX_COLS);
    else cols = CCW'(col_count_r);
  end

  // handshake
  assign in_tready = (pend_r < PEND_W'(FIFO_DEPTH));
  assign in_acc    = in_tvalid & in_tready;
  assign pix_acc   = in_acc & in_tuser;
  assign ref_acc   = in_acc & ~in_tuser;
  assign out_pop   = out_tvalid & out_tready;

  // reference fill, wrapping at the band count
  always_comb begin
    fill0        = (BCW'(ref_fill_r) >= bands) ? '0 : BCW'(ref_fill_r);
    fill_adv     = fill0 + BCW'(2);
    ref_fill_nxt = (fill_adv >= bands) ? '0 : BPW'(fill_adv);
    ref_hi_we    = ref_acc & ((fill0 + BCW'(1)) < bands);
    ref_waddr    = HAW'(fill0 >> 1);
  end

  // band, column and row progress of the pixel stream
  always_comb begin
    bp_ext       = BCW'(band_pos_r);
    hi_en        = (bp_ext + BCW'(1)) < bands;
    pix_end      = !((bp_ext + BCW'(2)) < bands);
    band_pos_nxt = pix_end ? '0 : BPW'(bp_ext + BCW'(2));
    ref_raddr    = HAW'(bp_ext >> 1);
    col_end      = !((CCW'(col_pos_r) + CCW'(1)) < cols);
    row_end      = !((RCW'(row_pos_r) + RCW'(1)) < rows);
    frame_end    = pix_end & col_end & row_end;
    col_pos_nxt  = col_pos_r;
    row_pos_nxt  = row_pos_r;
    if (pix_end) begin
      col_pos_nxt = col_end ? '0 : CPW'(CCW'(col_pos_r) + CCW'(1));
      if (col_end) begin
        row_pos_nxt = row_end ? '0 : RPW'(RCW'(row_pos_r) + RCW'(1));
      end
    end
  end

  // results owed: counted on the last word of a frame, released on output
  always_comb begin
    pend_nxt = pend_r + PEND_W'(pix_acc & frame_end) - PEND_W'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_fill_r <= '0;
      band_pos_r <= '0;
      row_pos_r  <= '0;
      col_pos_r  <= '0;
      pend_r     <= '0;
    end else begin
      if (ref_acc) begin
        ref_fill_r <= ref_fill_nxt;
      end
      if (pix_acc) begin
        band_pos_r <= band_pos_nxt;
        row_pos_r  <= row_pos_nxt;
        col_pos_r  <= col_pos_nxt;
      end
      pend_r <= pend_nxt;
    end
  end

  // reference banks: even bands and odd bands
  nabps_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HD)
  ) u_ref_even (
    .clk   (clk),
    .we    (ref_acc),
    .waddr (ref_waddr),
    .wdata (in_tdata[SAMPLE_W-1:0]),
    .raddr (ref_raddr),
    .rdata (ref_lo)
  );

  nabps_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HD)
  ) u_ref_odd (
    .clk   (clk),
    .we    (ref_hi_we),
    .waddr (ref_waddr),
    .wdata (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .raddr (ref_raddr),
    .rdata (ref_hi)
  );

  // first stage, aligned with the bank read data
  always_comb begin
    s1_ctl_nxt.valid     = pix_acc;
    s1_ctl_nxt.hi_en     = hi_en;
    s1_ctl_nxt.pix_end   = pix_end;
    s1_ctl_nxt.frame_end = frame_end;
    s1_ctl_nxt.row       = POS_W'(row_pos_r);
    s1_ctl_nxt.col       = POS_W'(col_pos_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_lo_r <= in_tdata[SAMPLE_W-1:0];
    s1_hi_r <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  end

  nabps_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_ctl   (s1_ctl_r),
    .s1_lo    (s1_lo_r),
    .s1_hi    (s1_hi_r),
    .ref_lo   (ref_lo),
    .ref_hi   (ref_hi),
    .pix_ctl  (pix_ctl),
    .pix_dist (pix_dist),
    .pix_sum  (pix_sum)
  );

  nabps_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix_ctl  (pix_ctl),
    .pix_dist (pix_dist),
    .pix_sum  (pix_sum),
    .res_push (res_push),
    .res      (res)
  );

  nabps_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .pop   (out_pop),
    .valid (out_tvalid),
    .full  (fifo_full),
    .dout  (head)
  );

  assign out_tdata = head;

  // checks
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(FIFO_DEPTH))
    else $error("outstanding result count beyond queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (!fifo_full || out_pop))
    else $error("result pushed into a full queue");

  a_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pend_r != '0))
    else $error("result shown with none owed");

  a_even_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (band_pos_r[0] == 1'b0) && (ref_fill_r[0] == 1'b0))
    else $error("band position or fill left the even word boundary");

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nabps_pkg::*;

  localparam int MAX_BANDS_P    = 256;
  localparam int MAX_ROWS_P     = 1024;
  localparam int MAX_COLS_P     = 1024;
  localparam int RANDOM_ITEMS   = 770;
  localparam int QUIET_IDLE_END = 640;
  localparam int SETTLE_CYCLES  = 12;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [DIST_W-1:0]     DIST_ONES    = '1;
  localparam logic [DIST_OUT_W-1:0] DIST_OUT_MAX = '1;
  localparam logic [SUM_W-1:0]      SUM_ONES     = '1;

  typedef enum logic {CMD_REF = 1'b0, CMD_PIXEL = 1'b1} command_e;
  typedef enum logic [1:0] {REG_BANDS = 2'd0, REG_ROWS = 2'd1, REG_COLS = 2'd2} reg_index_e;

  // tracks reference bands, pixel progress and both trackers; queues frame results
  class pixel_search_scoreboard;
    logic [8:0]       band_reg;
    logic [10:0]      row_reg;
    logic [10:0]      col_reg;
    logic [15:0]      ref_band [MAX_BANDS_P];
    int unsigned      ref_fill, band_pos, row_pos, col_pos;
    logic [DIST_W-1:0] dist_acc, best_dist;
    logic [SUM_W-1:0]  sum_acc, best_sum;
    logic [POS_W-1:0]  near_row, near_col, bright_row, bright_col;
    result_t           expected_results[$];
    int unsigned       errors;

    function new();
      band_reg = 9'd256;
      row_reg  = 11'd1024;
      col_reg  = 11'd1024;
      foreach (ref_band[i]) ref_band[i] = '0;
      ref_fill = 0;
      band_pos = 0;
      row_pos  = 0;
      col_pos  = 0;
      dist_acc = '0;
      sum_acc  = '0;
      errors   = 0;
      clear_trackers();
    endfunction

    function void clear_trackers();
      best_dist  = DIST_ONES;
      near_row   = '0;
      near_col   = '0;
      best_sum   = '0;
      bright_row = '0;
      bright_col = '0;
    endfunction

    function int unsigned clamp_count(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function void write_reg(reg_index_e idx, logic [10:0] val);
      case (idx)
        REG_BANDS: band_reg = val[8:0];
        REG_ROWS:  row_reg  = val;
        REG_COLS:  col_reg  = val;
        default: ;
      endcase
    endfunction

    // one band into both accumulators, saturating at their widths
    function void add_sample(int unsigned b, logic [15:0] s);
      longint unsigned r, d, acc;
      r = (b < MAX_BANDS_P) ? ref_band[b] : 0;
      d = (s > r) ? s - r : r - s;
      acc = longint'(dist_acc) + d * d;
      dist_acc = (acc > longint'(DIST_ONES)) ? DIST_ONES : acc[DIST_W-1:0];
      acc = longint'(sum_acc) + s;
      sum_acc = (acc > longint'(SUM_ONES)) ? SUM_ONES : acc[SUM_W-1:0];
    endfunction

    function void note_item(command_e cmd, logic [15:0] lo, logic [15:0] hi);
      int unsigned nb, nr, nc;
      result_t     res;
      nb = clamp_count(band_reg, MAX_BANDS_P);
      nr = clamp_count(row_reg, MAX_ROWS_P);
      nc = clamp_count(col_reg, MAX_COLS_P);

      // reference word: fill two bands, wrapping at the band count
      if (cmd == CMD_REF) begin
        if (ref_fill >= nb) ref_fill = 0;
        if (ref_fill < MAX_BANDS_P) ref_band[ref_fill] = lo;
        if (ref_fill + 1 < nb && ref_fill + 1 < MAX_BANDS_P) ref_band[ref_fill + 1] = hi;
        ref_fill += 2;
        if (ref_fill >= nb) ref_fill = 0;
        return;
      end

      add_sample(band_pos, lo);
      if (band_pos + 1 < nb) add_sample(band_pos + 1, hi);
      if (band_pos + 2 < nb) begin
        band_pos += 2;
        return;
      end

      // pixel complete: strict compares keep the earliest pixel
      band_pos = 0;
      if (dist_acc < best_dist) begin
        best_dist = dist_acc;
        near_row  = row_pos[POS_W-1:0];
        near_col  = col_pos[POS_W-1:0];
      end
      if (sum_acc > best_sum) begin
        best_sum   = sum_acc;
        bright_row = row_pos[POS_W-1:0];
        bright_col = col_pos[POS_W-1:0];
      end
      dist_acc = '0;
      sum_acc  = '0;

      if (col_pos + 1 < nc) begin
        col_pos++;
        return;
      end
      col_pos = 0;
      if (row_pos + 1 < nr) begin
        row_pos++;
        return;
      end
      row_pos = 0;

      // frame complete
      res.nearest_row     = near_row;
      res.nearest_col     = near_col;
      res.nearest_dist_sq = (best_dist > DIST_OUT_MAX) ? DIST_OUT_MAX : best_dist[DIST_OUT_W-1:0];
      res.bright_row      = bright_row;
      res.bright_col      = bright_col;
      res.bright_sum      = best_sum;
      expected_results.push_back(res);
      clear_trackers();
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no frame outstanding: %h", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("nearest_row", want.nearest_row, got.nearest_row);
      compare_field("nearest_col", want.nearest_col, got.nearest_col);
      compare_field("nearest_dist_sq", want.nearest_dist_sq, got.nearest_dist_sq);
      compare_field("bright_row", want.bright_row, got.bright_row);
      compare_field("bright_col", want.bright_col, got.bright_col);
      compare_field("bright_sum", want.bright_sum, got.bright_sum);
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [RES_W-1:0]  out_tdata;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index  = '0;
  logic [10:0]       cfg_data   = '0;

  pixel_search_scoreboard sb = new();

  bit          idle_on    = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] prev_pixel[$];

  nearest_and_brightest_pixel_search #(
    .MAX_BANDS(MAX_BANDS_P),
    .MAX_ROWS (MAX_ROWS_P),
    .MAX_COLS (MAX_COLS_P)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // handshake monitor: registers and items into the predictor, results against it
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(reg_index_e'(cfg_index), cfg_data);
      if (in_tvalid && in_tready)
        sb.note_item(command_e'(in_tuser), in_tdata[15:0], in_tdata[31:16]);
      if (out_tvalid && out_tready) sb.check_result(result_t'(out_tdata));
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // offer one item, with an occasional gap in front; returns after acceptance
  task automatic send_word(command_e cmd, logic [15:0] lo, logic [15:0] hi);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {hi, lo};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(reg_index_e idx, logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_counts(logic [10:0] bands, logic [10:0] rows, logic [10:0] cols);
    write_reg(REG_BANDS, bands);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, wait for every outstanding result, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // one frame of pixels with random content; ties by repeating the previous
  // pixel, stray reference words, and a frame cut short now and then (always past 300 words)
  task automatic send_frame(int unsigned nb, int unsigned nr, int unsigned nc);
    int unsigned wpp, total, cut, sent;
    logic [31:0] pix[$];
    wpp   = (nb + 1) / 2;
    total = wpp * nr * nc;
    if (total > 300) cut = $urandom_range(1, 40);
    else if ($urandom_range(0, 19) == 0) cut = $urandom_range(1, total);
    else cut = total;
    sent = 0;
    while (sent < cut) begin
      pix.delete();
      if (prev_pixel.size() == wpp && $urandom_range(0, 3) == 0) pix = prev_pixel;
      else repeat (wpp) pix.push_back({pick_sample(), pick_sample()});
      foreach (pix[i]) begin
        if (sent < cut) begin
          if ($urandom_range(0, 11) == 0) send_word(CMD_REF, pick_sample(), pick_sample());
          send_word(CMD_PIXEL, pix[i][15:0], pix[i][31:16]);
          sent++;
        end
      end
      prev_pixel = pix;
    end
  endtask

  initial begin
    int unsigned random_start, phase_no, nb, nr, nc, frames;
    logic [10:0] bands_v, rows_v, cols_v;
    int unsigned r;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full reference store of zeros, then one pixel of full-scale samples
    set_counts(11'd256, 11'd1, 11'd1);
    repeat (128) send_word(CMD_REF, 16'h0000, 16'h0000);
    repeat (128) send_word(CMD_PIXEL, 16'hFFFF, 16'hFFFF);
    settle();

    // single band: upper half ignored, zero row count acts as one, ties keep first
    set_counts(11'd1, 11'd0, 11'd3);
    send_word(CMD_REF, 16'h8000, 16'h1234);
    send_word(CMD_PIXEL, 16'h8000, 16'hFFFF);
    send_word(CMD_PIXEL, 16'h8000, 16'h0000);
    send_word(CMD_PIXEL, 16'hFFFF, 16'hFFFF);
    settle();

    // odd band count with reference wrap, then an all-zero frame
    set_counts(11'd3, 11'd1, 11'd2);
    send_word(CMD_REF, 16'h0001, 16'h0002);
    send_word(CMD_REF, 16'h0003, 16'hBEEF);
    send_word(CMD_REF, 16'h0010, 16'h0020);
    send_word(CMD_PIXEL, 16'h0000, 16'h0000);
    send_word(CMD_PIXEL, 16'h0000, 16'hFFFF);
    send_word(CMD_PIXEL, 16'h0000, 16'h0000);
    send_word(CMD_PIXEL, 16'h0000, 16'hFFFF);
    settle();

    // counts above range, then shrunk under the running positions
    set_counts(11'd511, 11'd2047, 11'd2047);
    send_word(CMD_PIXEL, 16'h1111, 16'h2222);
    send_word(CMD_PIXEL, 16'h3333, 16'h4444);
    settle();
    write_reg(REG_BANDS, 11'd0);
    cfg_valid <= 1'b0;
    send_word(CMD_PIXEL, 16'h5555, 16'h6666);
    send_word(CMD_PIXEL, 16'h7777, 16'h0000);
    send_word(CMD_PIXEL, 16'h0001, 16'h0000);
    settle();
    write_reg(REG_COLS, 11'd2);
    write_reg(REG_ROWS, 11'd1);
    cfg_valid <= 1'b0;
    send_word(CMD_PIXEL, 16'hABCD, 16'h0000);
    settle();

    // random phases of mostly small frames
    random_start = words_sent;
    phase_no = 0;
    while (words_sent - random_start < RANDOM_ITEMS) begin
      phase_no++;
      if (words_sent - random_start > QUIET_IDLE_END) idle_on = 1'b0;
      if (idle_on && phase_no % 15 == 2) begin
        // result per item while the receiver holds off: the block must stall
        set_counts(11'd1, 11'd1, 11'd1);
        hold_req = 1'b1;
        repeat (40) send_word(CMD_PIXEL, pick_sample(), pick_sample());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          case ($urandom_range(0, 2))
            0: bands_v = 11'd256;
            1: bands_v = 11'd300;
            default: bands_v = 11'd511;
          endcase
        end else if (r < 7) bands_v = 11'd0;
        else if (r < 21) bands_v = 11'($urandom_range(7, 20));
        else bands_v = 11'($urandom_range(1, 6));
        r = $urandom_range(0, 99);
        if (r < 4) rows_v = 11'd0;
        else if (r < 6) rows_v = 11'd2047;
        else if (r < 8) rows_v = 11'd1024;
        else rows_v = 11'($urandom_range(1, 3));
        r = $urandom_range(0, 99);
        if (r < 4) cols_v = 11'd0;
        else if (r < 6) cols_v = 11'd1024;
        else if (r < 8) cols_v = 11'd2000;
        else cols_v = 11'($urandom_range(1, 4));
        set_counts(bands_v, rows_v, cols_v);
        nb = sb.clamp_count(bands_v[8:0], MAX_BANDS_P);
        nr = sb.clamp_count(rows_v, MAX_ROWS_P);
        nc = sb.clamp_count(cols_v, MAX_COLS_P);
        frames = $urandom_range(1, 3);
        repeat (frames) send_frame(nb, nr, nc);
      end
      settle();
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
